@@ hdl/pdt_pkg.sv @@
package pdt_pkg;

    localparam int TIME_W      = 64;
    localparam int CFG_W       = 32;
    localparam int ELAPSED_W   = 32;
    localparam int CFG_INDEX_W = 2;

    // microseconds per second, 20 bits wide
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;

    // full-width scaled difference: diff * 10^6
    localparam int PROD_W = TIME_W + US_W;
    localparam int PART_W = CFG_W + US_W;

    // one quotient bit per step
    localparam int DIV_STEPS = ELAPSED_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]     PERIOD_RESET = 32'd10000;
    localparam logic [CFG_W-1:0]     FREQ_RESET   = 32'd10000000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQ   = 2'd1;

    typedef struct packed {
        logic load;      // take input beat, run deadline test
        logic mul_lo;    // low partial product
        logic mul_hi;    // high partial product, accumulate
        logic check;     // overflow test, seed remainder
        logic div_step;  // one quotient bit
        logic out_load;  // move result into output register
    } pdt_cmd_t;

    typedef struct packed {
        logic fire;      // input beat reaches the deadline
    } pdt_status_t;

endpackage

@@ hdl/periodic_deadline_timer.sv @@
// Periodic deadline timer.
// Input channel (in_valid / in_stall) carries one time reading, now_ticks,
// per beat. Each beat produces exactly one result beat on the output channel
// (out_valid / out_stall): fired, elapsed_micros and next_due.
// A beat at or past last firing + period fires: elapsed_micros is
// (now - last) * 10^6 / tick_frequency, truncated, saturating at 2^32-1
// (also for a zero frequency); the firing time moves to now and the next
// deadline is now + period. Otherwise elapsed_micros is 0 and the deadline is
// last + period. Deadline sums wrap at 64 bits.
// A firing beat passes through the 32x20 partial-product multiply (low half,
// then high half), an overflow check and the radix-2 divider, one quotient
// bit per cycle for 32 bits, before its result is loaded. A non-firing beat
// skips the arithmetic. No new beat is taken until the result has moved into
// the output register.
// The result sits in an output register; if the receiver stalls, the
// finished beat holds there and the next one waits in the datapath.
// Config writes (cfg_valid, always ready) set period_ticks (index 0) and
// tick_frequency (index 1); other indexes are dropped. Write only when idle.
// Reset: period 10000, frequency 10000000, last firing time 0, no result.
module periodic_deadline_timer
    import pdt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIME_W-1:0]      now_ticks,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   fired,
    output logic [ELAPSED_W-1:0]   elapsed_micros,
    output logic [TIME_W-1:0]      next_due
);

    pdt_cmd_t    cmd;
    pdt_status_t st;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: deadline test, multiply, overflow check, divide, hand-off
    pdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // config registers, firing time, multiplier, divider, result register
    pdt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .now_ticks      (now_ticks),
        .fired          (fired),
        .elapsed_micros (elapsed_micros),
        .next_due       (next_due)
    );

endmodule

@@ hdl/pdt_ctrl.sv @@
module pdt_ctrl
    import pdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  pdt_status_t st,
    output pdt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.mul_lo   = (state_reg == S_MUL_LO);
        cmd.mul_hi   = (state_reg == S_MUL_HI);
        cmd.check    = (state_reg == S_CHECK);
        cmd.div_step = (state_reg == S_DIV);
        cmd.out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= st.fire ? S_MUL_LO : S_DONE;
                end
                S_MUL_LO:
                    state_reg <= S_MUL_HI;
                S_MUL_HI:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (cmd.out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    // division always starts from step zero
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |=> (state_reg == S_DIV) && (cnt_reg == '0))
        else $error("divider started at nonzero step");

    // a beat that misses the deadline skips the arithmetic
    a_no_fire_short: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !st.fire) |=> (state_reg == S_DONE))
        else $error("non-firing beat entered the datapath sequence");

endmodule

@@ hdl/pdt_datapath.sv @@
module pdt_datapath
    import pdt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdt_cmd_t               cmd,
    output pdt_status_t            st,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [TIME_W-1:0]      now_ticks,
    output logic                   fired,
    output logic [ELAPSED_W-1:0]   elapsed_micros,
    output logic [TIME_W-1:0]      next_due
);

    logic [CFG_W-1:0]     period_reg;
    logic [CFG_W-1:0]     freq_reg;
    logic [TIME_W-1:0]    last_reg;

    logic                 fire_reg;
    logic [TIME_W-1:0]    diff_reg;
    logic [TIME_W-1:0]    nd_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [ELAPSED_W-1:0] quot_reg;
    logic                 sat_reg;

    logic                 fired_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [TIME_W-1:0]    deadline_reg;

    logic [TIME_W-1:0]    deadline;
    logic [TIME_W-1:0]    now_plus;
    logic [PART_W-1:0]    part_prod;
    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       trial_sub;
    logic                 q_bit;
    logic                 sat_next;

    // deadline test on the incoming beat
    assign deadline = last_reg + TIME_W'(period_reg);
    assign now_plus = now_ticks + TIME_W'(period_reg);
    assign st.fire  = (now_ticks >= deadline);

    // one 32x20 multiply per cycle, halves of the difference in turn
    assign part_prod = (cmd.mul_hi ? diff_reg[TIME_W-1:CFG_W] : diff_reg[CFG_W-1:0])
                       * US_PER_SECOND;

    // restoring division, low word of the product shifted in msb first
    assign trial     = {rem_reg, prod_reg[CFG_W-1]};
    assign trial_sub = trial - {1'b0, freq_reg};
    assign q_bit     = (trial >= {1'b0, freq_reg});

    // quotient needs more than 32 bits (also covers zero frequency)
    assign sat_next = (prod_reg[PROD_W-1:CFG_W] >= (PROD_W-CFG_W)'(freq_reg));

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        if (cmd.mul_lo)
            prod_next = PROD_W'(part_prod);
        else if (cmd.mul_hi)
            prod_next = prod_reg + {part_prod, {CFG_W{1'b0}}};
        else if (cmd.check)
            rem_next = prod_reg[2*CFG_W-1:CFG_W];
        else if (cmd.div_step)
        begin
            prod_next = prod_reg << 1;
            rem_next  = q_bit ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            freq_reg   <= FREQ_RESET;
            last_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_PERIOD))
                period_reg <= cfg_data;
            if (cfg_valid && (cfg_index == REG_FREQ))
                freq_reg <= cfg_data;
            if (cmd.load && st.fire)
                last_reg <= now_ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fire_reg <= st.fire;
            diff_reg <= now_ticks - last_reg;
            nd_reg   <= st.fire ? now_plus : deadline;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        if (cmd.check)
            sat_reg <= sat_next;
        if (cmd.div_step)
            quot_reg <= {quot_reg[ELAPSED_W-2:0], q_bit};
        if (cmd.out_load)
        begin
            fired_reg    <= fire_reg;
            elapsed_reg  <= !fire_reg ? '0 : (sat_reg ? ELAPSED_MAX : quot_reg);
            deadline_reg <= nd_reg;
        end
    end

    assign fired          = fired_reg;
    assign elapsed_micros = elapsed_reg;
    assign next_due       = deadline_reg;

    // partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat_reg) |-> (rem_reg < freq_reg))
        else $error("division remainder out of range");

endmodule
